// ----- sv/tlf_pkg.sv -----
// ----------------------------------------------------------------------------
// tlf_pkg: shared types and constants of the text line formatter
// Character codes, configuration register indexes and the job descriptor
// that travels from the front end to the output sequencer.
// ----------------------------------------------------------------------------
package tlf_pkg;

  localparam int NUMBER_DIGITS = 6;
  localparam int QUEUE_DEPTH   = 4;

  localparam logic [7:0] CH_SPACE    = 8'd32;
  localparam logic [7:0] CH_ZERO     = 8'd48;
  localparam logic [7:0] CH_TAB      = 8'd9;
  localparam logic [7:0] CH_NEWLINE  = 8'd10;
  localparam logic [7:0] CH_DOLLAR   = 8'd36;
  localparam logic [7:0] CH_CARET    = 8'd94;
  localparam logic [7:0] CTRL_OFFSET = 8'd64;
  localparam logic [7:0] CTRL_MAX    = 8'd31;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUMBER_MODE      = 3'd0,
    CFG_SQUEEZE_BLANK    = 3'd1,
    CFG_SHOW_ENDS        = 3'd2,
    CFG_SHOW_TABS        = 3'd3,
    CFG_SHOW_NONPRINTING = 3'd4
  } tlf_cfg_idx_e;

  typedef struct packed {
    logic [1:0] number_mode;
    logic       squeeze_blank;
    logic       show_ends;
    logic       show_tabs;
    logic       show_nonprinting;
  } tlf_cfg_t;

  // One queued job: an optional line number prefix, an optional lead byte
  // and the main byte that closes the run.
  typedef struct packed {
    logic       num_en;
    logic       pre_en;
    logic [7:0] pre_byte;
    logic [7:0] main_byte;
  } tlf_job_t;

endpackage

// ----- sv/tlf_front.sv -----
// ----------------------------------------------------------------------------
// tlf_front: input acceptance and classification
// Tracks line starts, blank lines and the BCD line counter, and turns each
// accepted byte into a job for the queue. Squeezed blank lines push nothing.
// ----------------------------------------------------------------------------
module tlf_front #(
  parameter int NumDigits = tlf_pkg::NUMBER_DIGITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tlf_pkg::tlf_cfg_t      cfg_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [7:0]             in_byte_i,
  input  logic                   file_start_i,
  input  logic                   full_i,
  output logic                   push_o,
  output tlf_pkg::tlf_job_t      job_o,
  output logic [4*NumDigits-1:0] digits_o
);

  localparam int NumW = 4 * NumDigits;

  logic [NumW-1:0] line_number_q, line_number_d;
  logic            at_line_start_q, at_line_start_d;
  logic            prev_line_blank_q, prev_line_blank_d;

  logic [NumW-1:0] number_inc;
  logic            accept;
  logic            is_nl;
  logic            prev_eff;
  logic            suppress;
  logic            do_number;

  // Digits below the first one that is not nine roll to zero; all nines hold.
  always_comb begin
    logic       lower_nines;
    logic [3:0] d;
    lower_nines = 1'b1;
    number_inc  = line_number_q;
    for (int j = 0; j < NumDigits; j++) begin
      d = line_number_q[4*j +: 4];
      if (lower_nines) begin
        number_inc[4*j +: 4] = (d == 4'd9) ? 4'd0 : d + 4'd1;
      end
      lower_nines = lower_nines && (d == 4'd9);
    end
    if (lower_nines) begin
      number_inc = line_number_q;
    end
  end

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign is_nl      = (in_byte_i == tlf_pkg::CH_NEWLINE);
  assign prev_eff   = prev_line_blank_q && !file_start_i;
  assign suppress   = at_line_start_q && is_nl && cfg_i.squeeze_blank && prev_eff;
  assign do_number  = at_line_start_q &&
                      (cfg_i.number_mode[1] ? !is_nl : cfg_i.number_mode[0]);

  always_comb begin
    line_number_d     = line_number_q;
    at_line_start_d   = at_line_start_q;
    prev_line_blank_d = prev_line_blank_q;
    if (accept) begin
      if (suppress) begin
        prev_line_blank_d = prev_eff;
      end else begin
        prev_line_blank_d = at_line_start_q ? is_nl : prev_eff;
        at_line_start_d   = is_nl;
        if (do_number) begin
          line_number_d = number_inc;
        end
      end
    end
  end

  always_comb begin
    job_o.num_en    = do_number;
    job_o.pre_en    = 1'b0;
    job_o.pre_byte  = tlf_pkg::CH_CARET;
    job_o.main_byte = in_byte_i;
    if (is_nl) begin
      job_o.pre_en   = cfg_i.show_ends;
      job_o.pre_byte = tlf_pkg::CH_DOLLAR;
    end else if (in_byte_i == tlf_pkg::CH_TAB) begin
      if (cfg_i.show_tabs) begin
        job_o.pre_en    = 1'b1;
        job_o.main_byte = in_byte_i + tlf_pkg::CTRL_OFFSET;
      end
    end else if (in_byte_i <= tlf_pkg::CTRL_MAX && cfg_i.show_nonprinting) begin
      job_o.pre_en    = 1'b1;
      job_o.main_byte = in_byte_i + tlf_pkg::CTRL_OFFSET;
    end
  end

  assign push_o   = accept && !suppress;
  assign digits_o = number_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_number_q     <= '0;
      at_line_start_q   <= 1'b1;
      prev_line_blank_q <= 1'b0;
    end else begin
      line_number_q     <= line_number_d;
      at_line_start_q   <= at_line_start_d;
      prev_line_blank_q <= prev_line_blank_d;
    end
  end

endmodule

// ----- sv/tlf_fifo.sv -----
// ----------------------------------------------------------------------------
// tlf_fifo: job queue between front end and output sequencer
// A small register queue with a first-word view of the head entry.
// ----------------------------------------------------------------------------
module tlf_fifo #(
  parameter int Width = 8,
  parameter int Depth = tlf_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] entries_q [Depth];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [CntW-1:0]  count_q;

  function automatic logic [PtrW-1:0] ptr_next(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign rdata_o = entries_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= ptr_next(wptr_q);
      end
      if (pop_i) begin
        rptr_q <= ptr_next(rptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("tlf_fifo: push into a full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("tlf_fifo: pop from an empty queue");

endmodule

// ----- sv/tlf_back.sv -----
// ----------------------------------------------------------------------------
// tlf_back: output sequencer
// Walks the head job through its byte positions (number digits, tab, lead
// byte, main byte), one byte per cycle while the output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module tlf_back #(
  parameter int NumDigits = tlf_pkg::NUMBER_DIGITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   head_valid_i,
  input  tlf_pkg::tlf_job_t      head_job_i,
  input  logic [4*NumDigits-1:0] head_digits_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [7:0]             out_byte_o,
  output logic                   last_of_run_o
);

  localparam int NumPos = NumDigits + 3;
  localparam int PosW   = $clog2(NumPos);
  localparam logic [PosW-1:0] PosTab  = PosW'(NumDigits);
  localparam logic [PosW-1:0] PosPre  = PosW'(NumDigits + 1);
  localparam logic [PosW-1:0] PosMain = PosW'(NumDigits + 2);

  logic [7:0]      seq_bytes [NumPos];
  logic [PosW-1:0] pos_q, pos_d, cur_pos, start_pos;
  logic            started_q, started_d;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_byte_q;
  logic            out_last_q;
  logic            load_ok;
  logic            emit;
  logic            is_last;

  // Position p shows digit NumDigits-1-p; zeros above the first nonzero
  // digit print as spaces, except the units digit.
  for (genvar p = 0; p < NumDigits; p++) begin : g_digit
    localparam int J = NumDigits - 1 - p;
    logic lead;
    assign lead = (head_digits_i[4*NumDigits-1:4*J] == '0) && (J != 0);
    assign seq_bytes[p] = lead ? tlf_pkg::CH_SPACE
                               : tlf_pkg::CH_ZERO + {4'd0, head_digits_i[4*J +: 4]};
  end
  assign seq_bytes[NumDigits]     = tlf_pkg::CH_TAB;
  assign seq_bytes[NumDigits + 1] = head_job_i.pre_byte;
  assign seq_bytes[NumDigits + 2] = head_job_i.main_byte;

  assign start_pos = head_job_i.num_en ? '0 : (head_job_i.pre_en ? PosPre : PosMain);
  assign cur_pos   = started_q ? pos_q : start_pos;
  assign load_ok   = !out_valid_q || !out_stall_i;
  assign emit      = head_valid_i && load_ok;
  assign is_last   = (cur_pos == PosMain);
  assign pop_o     = emit && is_last;

  always_comb begin
    pos_d       = pos_q;
    started_d   = started_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (emit) begin
      out_valid_d = 1'b1;
      started_d   = !is_last;
      if (cur_pos == PosTab) begin
        pos_d = head_job_i.pre_en ? PosPre : PosMain;
      end else if (cur_pos == PosPre) begin
        pos_d = PosMain;
      end else begin
        pos_d = cur_pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      started_q   <= started_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q <= seq_bytes[cur_pos];
      out_last_q <= is_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign last_of_run_o = out_last_q;

  // A job in progress stays at the head of the queue until its last byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni) started_q |-> head_valid_i)
    else $error("tlf_back: job left the queue before its last byte");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (emit && !is_last) |=> (started_q && out_valid_o && !out_last_q))
    else $error("tlf_back: run continuation lost");

endmodule

// ----- sv/text_line_formatter_unit.sv -----
// ----------------------------------------------------------------------------
// text_line_formatter_unit: line numbering and control byte display
// Formats a text byte stream: optional right-aligned BCD line numbers, blank
// line squeezing, end markers and caret notation for control bytes.
// ----------------------------------------------------------------------------
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------------
//   input   | in        | in_valid_i / in_stall_o | in_byte_i, file_start_i
//   output  | out       | out_valid_o/out_stall_i | out_byte_o, last_of_run_o
//   config  | in        | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// The front end takes one byte per cycle while the job queue has room.
// The output sequencer's byte rate, one byte per cycle unless the output
// stalls, sets the sustained item rate: one byte for a plain byte, two for
// a caret pair or marked newline, up to NumDigits+3 at a numbered line start.
// Reset clears the configuration, the line counter and the queue, and sets
// the block to a line start. Output stalls back up through the queue into
// in_stall_o; a squeezed blank line is taken without any transfer out.
// ----------------------------------------------------------------------------
module text_line_formatter_unit #(
  parameter int NumDigits = tlf_pkg::NUMBER_DIGITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tlf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tlf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     in_byte_i,
  input  logic                           file_start_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     out_byte_o,
  output logic                           last_of_run_o
);

  localparam int NumW   = 4 * NumDigits;
  localparam int JobW   = $bits(tlf_pkg::tlf_job_t);
  localparam int QWidth = JobW + NumW;
  localparam int QDepth = tlf_pkg::QUEUE_DEPTH;

  tlf_pkg::tlf_cfg_t cfg_q;
  tlf_pkg::tlf_job_t push_job, head_job;
  logic [NumW-1:0]   push_digits, head_digits;
  logic              push, pop, full, empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (tlf_pkg::tlf_cfg_idx_e'(cfg_idx_i))
        tlf_pkg::CFG_NUMBER_MODE:      cfg_q.number_mode      <= cfg_data_i[1:0];
        tlf_pkg::CFG_SQUEEZE_BLANK:    cfg_q.squeeze_blank    <= cfg_data_i[0];
        tlf_pkg::CFG_SHOW_ENDS:        cfg_q.show_ends        <= cfg_data_i[0];
        tlf_pkg::CFG_SHOW_TABS:        cfg_q.show_tabs        <= cfg_data_i[0];
        tlf_pkg::CFG_SHOW_NONPRINTING: cfg_q.show_nonprinting <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  tlf_front #(
    .NumDigits (NumDigits)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_byte_i    (in_byte_i),
    .file_start_i (file_start_i),
    .full_i       (full),
    .push_o       (push),
    .job_o        (push_job),
    .digits_o     (push_digits)
  );

  tlf_fifo #(
    .Width (QWidth),
    .Depth (QDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({push_digits, push_job}),
    .pop_i   (pop),
    .rdata_o ({head_digits, head_job}),
    .full_o  (full),
    .empty_o (empty)
  );

  tlf_back #(
    .NumDigits (NumDigits)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (!empty),
    .head_job_i    (head_job),
    .head_digits_i (head_digits),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule
